FILE: design/rlpwm_pkg.sv
`default_nettype none

package rlpwm_pkg;

  localparam int unsigned NUM_STEPS   = 32;
  localparam int unsigned STEP_W      = 5;
  localparam int unsigned LEVEL_W     = 5;
  localparam int unsigned PERIOD_W    = 12;
  localparam int unsigned GAMMA_W     = 5;
  localparam int unsigned PATTERN_W   = 16;
  localparam int unsigned LENGTH_W    = 16;
  localparam int unsigned MAX_LEDS    = 5;
  localparam int unsigned CH_PER_LED  = 3;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 12'd784;

  typedef enum logic [2:0] {
    MODE_STEP      = 3'd0,
    MODE_WRITE_ONE = 3'd1,
    MODE_WRITE_ALL = 3'd2,
    MODE_LATCH     = 3'd3,
    MODE_DISABLE   = 3'd4,
    MODE_ENABLE    = 3'd5
  } mode_t;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [STEP_W-1:0]  step_t;

  // gamma-corrected step weights
  function automatic logic [GAMMA_W-1:0] gamma_lut(input step_t step);
    logic [GAMMA_W-1:0] g;
    begin
      case (step)
        5'd0:  g = 5'd1;   5'd1:  g = 5'd1;   5'd2:  g = 5'd1;   5'd3:  g = 5'd1;
        5'd4:  g = 5'd1;   5'd5:  g = 5'd2;   5'd6:  g = 5'd1;   5'd7:  g = 5'd2;
        5'd8:  g = 5'd2;   5'd9:  g = 5'd3;   5'd10: g = 5'd2;   5'd11: g = 5'd3;
        5'd12: g = 5'd3;   5'd13: g = 5'd4;   5'd14: g = 5'd4;   5'd15: g = 5'd4;
        5'd16: g = 5'd5;   5'd17: g = 5'd6;   5'd18: g = 5'd7;   5'd19: g = 5'd7;
        5'd20: g = 5'd8;   5'd21: g = 5'd9;   5'd22: g = 5'd10;  5'd23: g = 5'd11;
        5'd24: g = 5'd13;  5'd25: g = 5'd14;  5'd26: g = 5'd16;  5'd27: g = 5'd18;
        5'd28: g = 5'd21;  5'd29: g = 5'd22;  5'd30: g = 5'd26;  5'd31: g = 5'd28;
        default: g = 5'd1;
      endcase
      return g;
    end
  endfunction

endpackage

`default_nettype wire

FILE: design/rgb_led_row_pwm_driver_core.sv
`default_nettype none
// A step word is held in the input stage, then loaded into the result register, before it is on out_.
// Throughput: one word per cycle while in_ready is high; mode words are absorbed in the input stage and give no result.
// in_ready drops only while the input stage holds a step word and the result register is full
// and not being taken.
// Reset (rst_n low, synchronous): levels cleared, step 0, latch disarmed, service window clear,
// drive enabled, base period 784, both stages empty.

module rgb_led_row_pwm_driver_core
  import rlpwm_pkg::*;
#(
  parameter int unsigned NUM_LEDS     = 5,
  parameter int unsigned SERVICE_STEP = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [PERIOD_W-1:0]   cfg_data,
  // input words
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2:0]            in_mode,
  input  wire logic [2:0]            in_led_index,
  input  wire logic [LEVEL_W-1:0]    in_red,
  input  wire logic [LEVEL_W-1:0]    in_green,
  input  wire logic [LEVEL_W-1:0]    in_blue,
  // result words
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PATTERN_W-1:0]       out_pattern,
  output logic [LENGTH_W-1:0]        out_step_length,
  output logic [STEP_W-1:0]          out_step_number,
  output logic                       out_service_window,
  output logic                       out_drive_enable
);

  localparam int unsigned CHANNELS = NUM_LEDS * CH_PER_LED;
  localparam int unsigned PROD_W   = PERIOD_W + GAMMA_W;

  // ------------------------------------------------------------------
  // Configuration register
  // ------------------------------------------------------------------
  logic [PERIOD_W-1:0] base_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_period_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      base_period_r <= cfg_data;
    end
  end

  // ------------------------------------------------------------------
  // Input stage: one word held, payload unreset
  // ------------------------------------------------------------------
  logic               s1_valid_r;
  logic [2:0]         s1_mode_r;
  logic [2:0]         s1_idx_r;
  level_t             s1_red_r;
  level_t             s1_green_r;
  level_t             s1_blue_r;

  logic               out_valid_r;
  logic               out_free;
  logic               s1_is_step;
  logic               s1_go;

  assign out_free   = !out_valid_r || out_ready;
  assign s1_is_step = (mode_t'(s1_mode_r) == MODE_STEP);
  // mode words never wait on the result side
  assign s1_go      = s1_valid_r && (!s1_is_step || out_free);
  assign in_ready   = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_mode_r  <= in_mode;
      s1_idx_r   <= in_led_index;
      s1_red_r   <= in_red;
      s1_green_r <= in_green;
      s1_blue_r  <= in_blue;
    end
  end

  // ------------------------------------------------------------------
  // Row state
  // ------------------------------------------------------------------
  level_t active_r  [CHANNELS];
  level_t pending_r [CHANNELS];
  level_t active_nxt  [CHANNELS];
  level_t pending_nxt [CHANNELS];
  step_t  step_cnt_r, step_cnt_nxt;
  logic   latch_r, latch_nxt;
  logic   window_r, window_nxt;
  logic   enable_r, enable_nxt;

  // step datapath
  logic [PATTERN_W-1:0] pattern;
  logic [PROD_W-1:0]    product;
  logic [LENGTH_W-1:0]  length;
  logic                 frame_end;

  always_comb begin
    pattern = '1;                        // bit 15 and absent LEDs stay high
    for (int ch = 0; ch < CHANNELS; ch++) begin
      pattern[PATTERN_W-2-ch] = (active_r[ch] >= step_cnt_r);
    end
  end

  assign product   = PROD_W'(base_period_r) * PROD_W'(gamma_lut(step_cnt_r));
  assign length    = (product > PROD_W'({LENGTH_W{1'b1}})) ? {LENGTH_W{1'b1}}
                                                           : product[LENGTH_W-1:0];
  assign frame_end = (step_cnt_r == step_t'(NUM_STEPS - 1));

  always_comb begin
    active_nxt   = active_r;
    pending_nxt  = pending_r;
    step_cnt_nxt = step_cnt_r;
    latch_nxt    = latch_r;
    window_nxt   = window_r;
    enable_nxt   = enable_r;
    if (s1_go) begin
      unique case (mode_t'(s1_mode_r)) inside
        MODE_STEP: begin
          if (step_cnt_r == '0) begin
            window_nxt = 1'b0;
          end
          step_cnt_nxt = step_cnt_r + step_t'(1);    // wraps to 0 after the last step
          if (step_cnt_r == step_t'(SERVICE_STEP - 1)) begin
            window_nxt = 1'b1;
          end
          if (frame_end && latch_r) begin
            active_nxt = pending_r;
            latch_nxt  = 1'b0;
          end
        end
        MODE_WRITE_ONE, MODE_WRITE_ALL: begin
          for (int led = 0; led < NUM_LEDS; led++) begin
            if (mode_t'(s1_mode_r) == MODE_WRITE_ALL || s1_idx_r == 3'(led)) begin
              pending_nxt[led*CH_PER_LED + 0] = s1_red_r;
              pending_nxt[led*CH_PER_LED + 1] = s1_green_r;
              pending_nxt[led*CH_PER_LED + 2] = s1_blue_r;
            end
          end
        end
        MODE_LATCH:   latch_nxt  = 1'b1;
        MODE_DISABLE: enable_nxt = 1'b0;
        MODE_ENABLE:  enable_nxt = 1'b1;
        default: ;                             // unused codes: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        active_r[ch]  <= '0;
        pending_r[ch] <= '0;
      end
      step_cnt_r <= '0;
      latch_r    <= 1'b0;
      window_r   <= 1'b0;
      enable_r   <= 1'b1;
    end else begin
      active_r   <= active_nxt;
      pending_r  <= pending_nxt;
      step_cnt_r <= step_cnt_nxt;
      latch_r    <= latch_nxt;
      window_r   <= window_nxt;
      enable_r   <= enable_nxt;
    end
  end

  // ------------------------------------------------------------------
  // Result register
  // ------------------------------------------------------------------
  logic                 step_go;
  logic [PATTERN_W-1:0] out_pattern_r;
  logic [LENGTH_W-1:0]  out_length_r;
  step_t                out_step_r;
  logic                 out_window_r;
  logic                 out_enable_r;

  assign step_go = s1_go && s1_is_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_pattern_r <= pattern;
      out_length_r  <= length;
      out_step_r    <= step_cnt_r;
      out_window_r  <= window_nxt;       // flag as left by this step
      out_enable_r  <= enable_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pattern        = out_pattern_r;
  assign out_step_length    = out_length_r;
  assign out_step_number    = out_step_r;
  assign out_service_window = out_window_r;
  assign out_drive_enable   = out_enable_r;

  // ------------------------------------------------------------------
  // Checks
  // ------------------------------------------------------------------
  a_step_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    step_go |=> out_valid && out_step_number == $past(step_cnt_r))
    else $error("step word not loaded into result register");

  a_counter_follows: assert property (@(posedge clk) disable iff (!rst_n)
    step_go |=> step_cnt_r == $past(step_cnt_r) + step_t'(1))
    else $error("step counter did not advance");

  a_latch_cleared_at_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    step_go && frame_end |=> !latch_r)
    else $error("latch still armed after frame end");

  a_window_opens: assert property (@(posedge clk) disable iff (!rst_n)
    step_go && step_cnt_r == step_t'(SERVICE_STEP - 1) |=> window_r && out_service_window)
    else $error("service window not set at service step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !step_go)
    else $error("pending result overwritten");

endmodule

`default_nettype wire
